FILE: hdl/first_fit_block_allocator_defines.svh
// Assertion macros for the first-fit block allocator.
// Included by files that carry concurrent assertions.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/ffa_pkg.sv
// Package for the first-fit block allocator: constants, status codes, types.
// No dependencies.
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int MaxBlocksDef   = 32;
  localparam int HeaderBytesDef = 16;
  localparam int PoolMaxDef     = 65536;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_NULL    = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;
  localparam logic [2:0] ST_NOTUSED = 3'd5;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_SCAN_WAIT, S_SHIFT, S_SPLIT,
    S_FREE_CHK, S_MERGE, S_DONE
  } state_t;

  // Result bundle handed from the sequencer to the output register.
  typedef struct packed {
    logic [15:0] data_offset;
    logic [2:0]  status;
  } result_t;

  // Table memory write command.
  typedef struct packed {
    logic        we;
    logic [15:0] start;
    logic [16:0] bytes;
    logic        used;
  } tbl_wr_t;
endpackage

FILE: hdl/first_fit_block_allocator.sv
// First-fit block allocator over a byte pool.
// Requests enter on the in_ stream (kind, request_bytes, release_offset).
// Each request produces one result on the out_ stream (data_offset, status).
// The cfg_ channel sets the pool size (saturated to 64..65536) and resets
// the table to one free block; write it only while idle.
// One request at a time: in_tready is high only while the sequencer is idle
// and the output register is empty. out_tvalid rises once the sequencer
// reaches S_DONE and its result is registered. A rejected request goes
// there straight from idle; any other request first scans the table and,
// for a split or a free, shifts and splits or merges entries, walking the
// table memory (one write, one read port) one entry per cycle.
// After reset the S_INIT state writes the initial block, then requests are taken.
// A stalled out_tready holds the result and blocks new requests.
// in_tdata: [15:0] request_bytes, [31:16] release_offset; in_tuser: kind.
// out_tdata: [15:0] data_offset; out_tuser: status.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffa_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffa_pkg::HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes, release_offset
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data_offset
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);
  import ffa_pkg::*;

  logic        busy, done, start, cfg_fire;
  result_t     res;
  logic [16:0] pool_r, pool_nxt;
  logic        ov_r;
  result_t     ores_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign pool_nxt  = (cfg_data < 17'd64) ? 17'd64 :
                     (cfg_data > 17'(PoolMaxDef)) ? 17'(PoolMaxDef) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= 17'd65536;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_fire) pool_r <= pool_nxt;
      if (done) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (done) ores_r <= res;
  end

  assign in_tready = !busy && !ov_r && !cfg_fire;
  assign start     = in_tvalid && in_tready;

  ffa_seq #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_tuser),
    .req_bytes(in_tdata[15:0]), .rel_off(in_tdata[31:16]),
    .init(cfg_fire), .pool(cfg_fire ? pool_nxt : pool_r),
    .busy(busy), .done(done), .res(res)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = ores_r.data_offset;
  assign out_tuser  = ores_r.status;

  `FFA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, start, !ov_r)
  `FFA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !cfg_fire, busy)
  `FFA_ASSERT_IMPL(a_done_empty, clk, rst_n, done, !ov_r)
endmodule

FILE: hdl/ffa_table.sv
// Block table memory: start, size and used mark per entry.
// One write port and one registered read port. Uses ffa_pkg.
`timescale 1ns / 1ps
module ffa_table #(
  parameter int MAX_BLOCKS = ffa_pkg::MaxBlocksDef,
  parameter int AW = $clog2(MAX_BLOCKS)
) (
  input  logic                clk,
  input  ffa_pkg::tbl_wr_t    wr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [AW-1:0]       rd_addr,
  output logic [15:0]         rd_start,
  output logic [16:0]         rd_bytes,
  output logic                rd_used
);
  import ffa_pkg::*;
  logic [33:0] mem [MAX_BLOCKS];
  logic [33:0] rd_q;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= {wr.start, wr.bytes, wr.used};
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_start = rd_q[33:18];
  assign rd_bytes = rd_q[17:1];
  assign rd_used  = rd_q[0];
endmodule

FILE: hdl/ffa_seq.sv
// Sequencer for the allocator: scans, shifts and merges table entries
// one per cycle through the table memory. Uses ffa_pkg and ffa_table.
`timescale 1ns / 1ps
module ffa_seq #(
  parameter int MAX_BLOCKS   = ffa_pkg::MaxBlocksDef,
  parameter int HEADER_BYTES = ffa_pkg::HeaderBytesDef,
  parameter int AW = $clog2(MAX_BLOCKS),
  parameter int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              kind,
  input  logic [15:0]       req_bytes,
  input  logic [15:0]       rel_off,
  input  logic              init,
  input  logic [16:0]       pool,
  output logic              busy,
  output logic              done,
  output ffa_pkg::result_t  res
);
  import ffa_pkg::*;

  localparam logic [16:0] HDR = 17'(HEADER_BYTES);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;     // entry under work
  logic [AW-1:0]  ptr_r, ptr_nxt;     // shift pointer
  logic [CW-1:0]  rd_i_r, rd_i_nxt;   // index whose data arrives next
  logic           kind_r, kind_nxt;
  logic [16:0]    sz_r, sz_nxt;
  logic [15:0]    hdr_r, hdr_nxt;
  logic [15:0]    cur_start_r, cur_start_nxt;
  logic [16:0]    cur_bytes_r, cur_bytes_nxt;
  logic           nxt_free_r, nxt_free_nxt;  // right neighbor free
  logic           prv_free_r, prv_free_nxt;  // left neighbor free
  logic [15:0]    prv_start_r, prv_start_nxt;
  logic [16:0]    prv_bytes_r, prv_bytes_nxt;
  logic [16:0]    nb_bytes_r, nb_bytes_nxt;
  logic [1:0]     ph_r, ph_nxt;
  result_t        res_r, res_nxt;

  tbl_wr_t        wr;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [15:0]    rd_start;
  logic [16:0]    rd_bytes;
  logic           rd_used;

  ffa_table #(.MAX_BLOCKS(MAX_BLOCKS), .AW(AW)) u_tbl (
    .clk(clk), .wr(wr), .wr_addr(wr_addr), .rd_addr(rd_addr),
    .rd_start(rd_start), .rd_bytes(rd_bytes), .rd_used(rd_used)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= CW'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r <= idx_nxt; ptr_r <= ptr_nxt; rd_i_r <= rd_i_nxt; kind_r <= kind_nxt;
    sz_r <= sz_nxt; hdr_r <= hdr_nxt; cur_start_r <= cur_start_nxt;
    cur_bytes_r <= cur_bytes_nxt; nxt_free_r <= nxt_free_nxt;
    prv_free_r <= prv_free_nxt; prv_start_r <= prv_start_nxt;
    prv_bytes_r <= prv_bytes_nxt; nb_bytes_r <= nb_bytes_nxt; ph_r <= ph_nxt;
    res_r <= res_nxt;
  end

  // The memory is written with the reset/config pool as entry 0; the read
  // side only ever looks at entries below the count.
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; ptr_nxt = ptr_r;
    rd_i_nxt = rd_i_r; kind_nxt = kind_r; sz_nxt = sz_r; hdr_nxt = hdr_r;
    cur_start_nxt = cur_start_r; cur_bytes_nxt = cur_bytes_r;
    nxt_free_nxt = nxt_free_r; prv_free_nxt = prv_free_r;
    prv_start_nxt = prv_start_r; prv_bytes_nxt = prv_bytes_r;
    nb_bytes_nxt = nb_bytes_r; ph_nxt = ph_r; res_nxt = res_r;
    wr = '0; wr_addr = '0; rd_addr = '0;
    done = 1'b0;
    if (init) begin
      state_nxt = S_INIT;
    end else begin
      unique case (state_r)
        S_INIT: begin
          wr.we = 1'b1; wr.start = '0; wr.bytes = pool - HDR; wr.used = 1'b0;
          wr_addr = '0; cnt_nxt = CW'(1); state_nxt = S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            kind_nxt = kind; sz_nxt = {1'b0, req_bytes};
            hdr_nxt = rel_off - 16'(HEADER_BYTES);
            res_nxt = '{data_offset: '0, status: ST_OK};
            idx_nxt = '0; rd_addr = '0; rd_i_nxt = '0;
            prv_free_nxt = 1'b0; ph_nxt = '0;
            if (kind == KIND_ALLOC && req_bytes == '0) begin
              res_nxt.status = ST_ZERO; state_nxt = S_DONE;
            end else if (kind == KIND_FREE && rel_off == '0) begin
              res_nxt.status = ST_NULL; state_nxt = S_DONE;
            end else if (kind == KIND_FREE && ({1'b0, rel_off} < HDR ||
                         ({1'b0, rel_off} - HDR) >= pool)) begin
              res_nxt.status = ST_RANGE; state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // data of entry rd_i_r is valid; prefetch next
          rd_addr = AW'(rd_i_r + CW'(1));
          rd_i_nxt = rd_i_r + CW'(1);
          cur_start_nxt = rd_start; cur_bytes_nxt = rd_bytes;
          idx_nxt = AW'(rd_i_r);
          if (rd_i_r >= cnt_r) begin
            res_nxt.status = (kind_r == KIND_ALLOC) ? ST_NOSPACE : ST_NOTUSED;
            state_nxt = S_DONE;
          end else if (kind_r == KIND_ALLOC) begin
            if (!rd_used && rd_bytes >= sz_r) begin
              res_nxt.data_offset = rd_start + 16'(HEADER_BYTES);
              if (rd_bytes > sz_r + HDR && cnt_r < CW'(MAX_BLOCKS)) begin
                ptr_nxt = AW'(cnt_r - CW'(1));
                rd_addr = AW'(cnt_r - CW'(1));
                state_nxt = S_SHIFT;
              end else begin
                wr.we = 1'b1; wr_addr = AW'(rd_i_r); wr.start = rd_start;
                wr.bytes = rd_bytes; wr.used = 1'b1; state_nxt = S_DONE;
              end
            end
          end else begin
            if (rd_start == hdr_r) begin
              if (!rd_used) begin
                res_nxt.status = ST_NOTUSED; state_nxt = S_DONE;
              end else begin
                rd_addr = AW'(rd_i_r + CW'(1));
                state_nxt = S_FREE_CHK;
              end
            end else begin
              prv_free_nxt = !rd_used; prv_start_nxt = rd_start;
              prv_bytes_nxt = rd_bytes;
            end
          end
        end
        S_SHIFT: begin
          // move entry ptr to ptr+1, walking down to idx+1
          rd_addr = ptr_r;
          if (ph_r == 2'd0) begin
            ph_nxt = 2'd1;
          end else begin
            if (ptr_r == idx_r) begin
              state_nxt = S_SPLIT;
            end else begin
              wr.we = 1'b1; wr_addr = AW'(ptr_r + AW'(1)); wr.start = rd_start;
              wr.bytes = rd_bytes; wr.used = rd_used;
              ptr_nxt = ptr_r - AW'(1); rd_addr = ptr_r - AW'(1);
              ph_nxt = 2'd1;
            end
          end
        end
        S_SPLIT: begin
          if (ph_r != 2'd2) begin
            wr.we = 1'b1; wr_addr = idx_r + AW'(1);
            wr.start = cur_start_r + 16'(HEADER_BYTES) + sz_r[15:0];
            wr.bytes = cur_bytes_r - sz_r - HDR; wr.used = 1'b0;
            ph_nxt = 2'd2;
          end else begin
            wr.we = 1'b1; wr_addr = idx_r; wr.start = cur_start_r;
            wr.bytes = sz_r; wr.used = 1'b1;
            cnt_nxt = cnt_r + CW'(1); state_nxt = S_DONE;
          end
        end
        S_FREE_CHK: begin
          // rd data = entry idx+1
          nxt_free_nxt = (CW'(idx_r) + CW'(1) < cnt_r) && !rd_used;
          nb_bytes_nxt = rd_bytes;
          ph_nxt = 2'd0;
          if (prv_free_r) begin
            // merge into left neighbor, maybe also right
            idx_nxt = idx_r - AW'(1); cur_start_nxt = prv_start_r;
            cur_bytes_nxt = prv_bytes_r + HDR + cur_bytes_r;
          end
          state_nxt = S_MERGE;
        end
        S_MERGE: begin
          // drop dels entries after idx (0, 1 or 2), then write merged idx
          if (ph_r == 2'd0) begin
            if (nxt_free_r) cur_bytes_nxt = cur_bytes_r + HDR + nb_bytes_r;
            ptr_nxt = idx_r + AW'(1)
                    + AW'({1'b0, prv_free_r} + {1'b0, nxt_free_r});
            rd_addr = idx_r + AW'(1)
                    + AW'({1'b0, prv_free_r} + {1'b0, nxt_free_r});
            ph_nxt = 2'd1;
            if (!prv_free_r && !nxt_free_r) begin
              ph_nxt = 2'd3;
            end else if (CW'(idx_r) + CW'(1)
                         + CW'({1'b0, prv_free_r} + {1'b0, nxt_free_r}) >= cnt_r) begin
              // nothing above the dropped entries
              ph_nxt = 2'd3;
            end
          end else if (ph_r == 2'd1) begin
            rd_addr = ptr_r + AW'(1);
            if (CW'(ptr_r) >= cnt_r) begin
              ph_nxt = 2'd3;
            end else begin
              wr.we = 1'b1;
              wr_addr = ptr_r - AW'({1'b0, prv_free_r} + {1'b0, nxt_free_r});
              wr.start = rd_start; wr.bytes = rd_bytes; wr.used = rd_used;
              ptr_nxt = ptr_r + AW'(1);
              if (CW'(ptr_r) + CW'(1) >= cnt_r) ph_nxt = 2'd3;
            end
          end else begin
            wr.we = 1'b1; wr_addr = idx_r; wr.start = cur_start_r;
            wr.bytes = cur_bytes_r; wr.used = 1'b0;
            cnt_nxt = cnt_r - CW'({1'b0, prv_free_r} + {1'b0, nxt_free_r});
            state_nxt = S_DONE;
          end
        end
        S_DONE: begin
          done = 1'b1; state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;
endmodule
